[hw/rtl/esa_pkg.sv]
// ----------------------------------------------------------------------------
// esa_pkg
// Types and constants shared by the elasticity stencil blocks.
// ----------------------------------------------------------------------------
package esa_pkg;

	localparam int IDX_W   = 3;
	localparam int DATA_W  = 32;
	localparam int CONST_W = 31;
	localparam int RW_W    = 11;
	localparam int ROW_W   = 20;
	localparam int COL_W   = 10;
	localparam int DIFF_W  = 36;
	localparam int OP_W    = 64;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_MU_UPPER     = 3'd0;
	localparam logic [IDX_W-1:0] REG_LAMBDA_UPPER = 3'd1;
	localparam logic [IDX_W-1:0] REG_MU_LOWER     = 3'd2;
	localparam logic [IDX_W-1:0] REG_LAMBDA_LOWER = 3'd3;
	localparam logic [IDX_W-1:0] REG_INV_CELL_X   = 3'd4;
	localparam logic [IDX_W-1:0] REG_INV_CELL_Y   = 3'd5;
	localparam logic [IDX_W-1:0] REG_ROW_WIDTH    = 3'd6;
	localparam logic [IDX_W-1:0] REG_UPPER_START  = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [CONST_W-1:0] RST_MU_UPPER     = 31'd65536;
	localparam logic [CONST_W-1:0] RST_LAMBDA_UPPER = 31'd65536;
	localparam logic [CONST_W-1:0] RST_MU_LOWER     = 31'd131072;
	localparam logic [CONST_W-1:0] RST_LAMBDA_LOWER = 31'd65536;
	localparam logic [CONST_W-1:0] RST_INV_CELL     = 31'd65536;
	localparam logic [RW_W-1:0]    RST_ROW_WIDTH    = 11'd1024;
	localparam logic [ROW_W-1:0]   RST_UPPER_START  = 20'd0;

	// Rounding shift of a product: by FRAC_BITS, one more, or two more.
	localparam logic [1:0] SH_F  = 2'd0;
	localparam logic [1:0] SH_F1 = 2'd1;
	localparam logic [1:0] SH_F2 = 2'd2;

	typedef struct packed {
		logic [CONST_W-1:0] mu_upper;
		logic [CONST_W-1:0] lambda_upper;
		logic [CONST_W-1:0] mu_lower;
		logic [CONST_W-1:0] lambda_lower;
		logic [CONST_W-1:0] inv_cell_x;
		logic [CONST_W-1:0] inv_cell_y;
		logic [RW_W-1:0]    row_width;
		logic [ROW_W-1:0]   upper_start_row;
	} esa_cfg_t;

	// One interior point: the window differences of both components.
	typedef struct packed {
		logic [1:0][DIFF_W-1:0] d2x;
		logic [1:0][DIFF_W-1:0] d2y;
		logic [1:0][DIFF_W-1:0] dm;
		logic [1:0][DIFF_W-1:0] ddx;
		logic [1:0][DIFF_W-1:0] ddy;
		logic [COL_W-1:0]       col;
		logic [ROW_W-1:0]       row;
	} esa_item_t;

	typedef struct packed {
		logic            start;
		logic [OP_W-1:0] a;
		logic [OP_W-1:0] b;
		logic [1:0]      sh;
	} esa_mul_req_t;

	typedef struct packed {
		logic            done;
		logic [OP_W-1:0] res;
		logic            clip;
	} esa_mul_rsp_t;

endpackage

[hw/rtl/esa_front.sv]
// ----------------------------------------------------------------------------
// esa_front
// Raster counters, two line buffers and the 3x3 window; emits differences.
// ----------------------------------------------------------------------------
module esa_front import esa_pkg::*; #(
	parameter int ROW_MAX = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RW_W-1:0]    row_width,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] disp_x,
	input  logic signed [31:0] disp_y,
	input  logic               frame_start,
	input  logic               q_full,
	output logic               q_push,
	output esa_item_t          q_item
);

	localparam int CW = $clog2(ROW_MAX);
	localparam int WW = CW + 1;

	localparam logic [1:0] F_ACC  = 2'd0;
	localparam logic [1:0] F_UPD  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]       fst_q;
	logic [CW-1:0]    col_q, c_q;
	logic [ROW_W-1:0] row_q, r_q;
	logic             prod_q;
	logic [63:0]      sample_q, rdp_q, rdp2_q;
	logic [63:0]      win_q [9];
	logic [63:0]      nwin  [9];
	logic [63:0]      mem_prev  [ROW_MAX];
	logic [63:0]      mem_prev2 [ROW_MAX];
	esa_item_t        item_q, item_d;

	logic             accept;
	logic [WW-1:0]    w_eff, cn;
	logic [CW-1:0]    col0, c;
	logic [ROW_W-1:0] row0, r;

	assign in_ready = (fst_q == F_ACC);
	assign accept   = in_valid && in_ready;
	assign q_push   = (fst_q == F_PUSH) && !q_full;
	assign q_item   = item_q;

	always_comb begin
		if (row_width < RW_W'(3)) begin
			w_eff = WW'(3);
		end else if (32'(row_width) > ROW_MAX) begin
			w_eff = WW'(ROW_MAX);
		end else begin
			w_eff = WW'(row_width);
		end
		col0 = frame_start ? '0 : col_q;
		row0 = frame_start ? '0 : row_q;
		if (WW'(col0) >= w_eff) begin
			c = '0;
			r = row0 + 1'b1;
		end else begin
			c = col0;
			r = row0;
		end
		cn = WW'(c) + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_ACC;
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			unique case (fst_q)
				F_ACC: begin
					if (accept) begin
						fst_q <= F_UPD;
						if (cn >= w_eff) begin
							col_q <= '0;
							row_q <= r + 1'b1;
						end else begin
							col_q <= cn[CW-1:0];
							row_q <= r;
						end
					end
				end
				F_UPD: begin
					for (int i = 0; i < 9; i++) win_q[i] <= nwin[i];
					fst_q <= prod_q ? F_PUSH : F_ACC;
				end
				F_PUSH: begin
					if (!q_full) fst_q <= F_ACC;
				end
				default: fst_q <= F_ACC;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q      <= c;
			r_q      <= r;
			prod_q   <= (c >= CW'(2)) && (r >= ROW_W'(2));
			sample_q <= {disp_y, disp_x};
		end
		if (fst_q == F_UPD) item_q <= item_d;
	end

	// Line buffers: read at the column on accept, written back the next cycle.
	always_ff @(posedge clk) begin
		if (accept) rdp_q <= mem_prev[c];
		if (fst_q == F_UPD) mem_prev[c_q] <= sample_q;
	end

	always_ff @(posedge clk) begin
		if (accept) rdp2_q <= mem_prev2[c];
		if (fst_q == F_UPD) mem_prev2[c_q] <= rdp_q;
	end

	always_comb begin
		nwin[0] = win_q[1]; nwin[1] = win_q[2]; nwin[2] = rdp2_q;
		nwin[3] = win_q[4]; nwin[4] = win_q[5]; nwin[5] = rdp_q;
		nwin[6] = win_q[7]; nwin[7] = win_q[8]; nwin[8] = sample_q;
	end

	always_comb begin
		logic signed [DIFF_W-1:0] v [9];
		item_d     = '0;
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < 9; i++) begin
				v[i] = DIFF_W'($signed(nwin[i][32*k +: 32]));
			end
			item_d.d2x[k] = v[5] - (v[4] <<< 1) + v[3];
			item_d.d2y[k] = v[7] - (v[4] <<< 1) + v[1];
			item_d.dm[k]  = v[8] + v[0] - v[2] - v[6];
			item_d.ddx[k] = v[5] - v[3];
			item_d.ddy[k] = v[7] - v[1];
		end
		item_d.col = COL_W'(c_q - CW'(2));
		item_d.row = r_q;
	end

endmodule

[hw/rtl/esa_queue.sv]
// ----------------------------------------------------------------------------
// esa_queue
// Two-entry queue between the window front and the arithmetic back.
// ----------------------------------------------------------------------------
module esa_queue import esa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  esa_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      valid,
	output esa_item_t head
);

	esa_item_t  ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end

endmodule

[hw/rtl/esa_qmul.sv]
// ----------------------------------------------------------------------------
// esa_qmul
// Shared fixed-point multiplier: four 32x32 partial products, rounding, clip.
// ----------------------------------------------------------------------------
module esa_qmul import esa_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  esa_mul_req_t req,
	output esa_mul_rsp_t rsp
);

	localparam logic [63:0] LIM = (64'd1 << 60) - 64'd1;

	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  ua_q, ub_q, pp_q, res_q;
	logic         neg_q, clip_q;
	logic [1:0]   sh_q, pp_idx_q;
	logic [127:0] acc_q, pp_sh, shifted, half;
	logic [7:0]   shamt;
	logic [31:0]  a_part, b_part;
	logic [63:0]  mag;
	logic         over;

	assign a_part = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign b_part = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign shamt  = 8'(FRAC_BITS) + {6'd0, sh_q};
	assign half   = 128'd1 << (shamt - 8'd1);
	assign shifted = acc_q >> shamt;
	assign over   = |shifted[127:60];
	assign mag    = over ? LIM : {4'd0, shifted[59:0]};

	always_comb begin
		case (pp_idx_q)
			2'd0:    pp_sh = {64'd0, pp_q};
			2'd3:    pp_sh = {pp_q, 64'd0};
			default: pp_sh = {32'd0, pp_q, 32'd0};
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;
	assign rsp.clip = clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd6) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= req.a[63] ? (64'd0 - req.a) : req.a;
			ub_q  <= req.b[63] ? (64'd0 - req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
			sh_q  <= req.sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q     <= 64'(a_part) * 64'(b_part);
				pp_idx_q <= cnt_q[1:0];
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) acc_q <= acc_q + pp_sh;
			if (cnt_q == 3'd5) acc_q <= acc_q + half;
			if (cnt_q == 3'd6) begin
				res_q  <= neg_q ? (64'd0 - mag) : mag;
				clip_q <= over;
			end
		end
	end

endmodule

[hw/rtl/esa_back.sv]
// ----------------------------------------------------------------------------
// esa_back
// Sequencer that runs the force terms through the shared multiplier.
// ----------------------------------------------------------------------------
module esa_back import esa_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  esa_cfg_t           cfg,
	input  logic               q_valid,
	input  esa_item_t          q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic [COL_W-1:0]   out_column,
	output logic [ROW_W-1:0]   out_row,
	output logic               saturated
);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_ISSUE = 2'd1;
	localparam logic [1:0] B_WAIT  = 2'd2;
	localparam logic [1:0] B_FIN   = 2'd3;

	localparam logic [4:0] LAST_STEP = 5'd25;
	localparam logic [4:0] LAST_FX   = 5'd20;

	logic [1:0]         bst_q;
	logic [4:0]         step_q;
	esa_item_t          item_q;
	logic signed [63:0] res_q [16];
	logic signed [63:0] fx_q, fy_q;
	logic               clip_q, out_valid_q;
	esa_mul_req_t       req;
	esa_mul_rsp_t       rsp;

	logic signed [63:0] ix, iy, mu, lam, mua, lama, mub, lamb, opa, opb;
	logic signed [63:0] nfx, nfy, cx, cy;
	logic               sx, sy;
	logic [1:0]         sh;
	logic [ROW_W-1:0]   r1, r2;

	function automatic logic signed [63:0] sx36(input logic [DIFF_W-1:0] d);
		return 64'($signed(d));
	endfunction

	// Material constants for the point row and the rows above and below it.
	always_comb begin
		r1  = item_q.row - ROW_W'(1);
		r2  = item_q.row - ROW_W'(2);
		ix  = {33'd0, cfg.inv_cell_x};
		iy  = {33'd0, cfg.inv_cell_y};
		mu  = {33'd0, (r1 >= cfg.upper_start_row) ? cfg.mu_upper : cfg.mu_lower};
		lam = {33'd0, (r1 >= cfg.upper_start_row) ? cfg.lambda_upper : cfg.lambda_lower};
		mua = {33'd0, (item_q.row >= cfg.upper_start_row) ? cfg.mu_upper : cfg.mu_lower};
		lama = {33'd0, (item_q.row >= cfg.upper_start_row) ? cfg.lambda_upper
			: cfg.lambda_lower};
		mub = {33'd0, (r2 >= cfg.upper_start_row) ? cfg.mu_upper : cfg.mu_lower};
		lamb = {33'd0, (r2 >= cfg.upper_start_row) ? cfg.lambda_upper : cfg.lambda_lower};
	end

	// Step table: scales, derivatives, material gradients, then force terms.
	always_comb begin
		opa = '0;
		opb = '0;
		sh  = SH_F;
		unique case (step_q)
			5'd0:  begin opa = ix; opb = ix; end
			5'd1:  begin opa = iy; opb = iy; end
			5'd2:  begin opa = ix; opb = iy; end
			5'd3:  begin opa = sx36(item_q.d2x[0]); opb = res_q[0]; end
			5'd4:  begin opa = sx36(item_q.d2x[1]); opb = res_q[0]; end
			5'd5:  begin opa = sx36(item_q.d2y[0]); opb = res_q[1]; end
			5'd6:  begin opa = sx36(item_q.d2y[1]); opb = res_q[1]; end
			5'd7:  begin opa = sx36(item_q.dm[0]); opb = res_q[2]; sh = SH_F2; end
			5'd8:  begin opa = sx36(item_q.dm[1]); opb = res_q[2]; sh = SH_F2; end
			5'd9:  begin opa = sx36(item_q.ddx[0]); opb = ix; sh = SH_F1; end
			5'd10: begin opa = sx36(item_q.ddx[1]); opb = ix; sh = SH_F1; end
			5'd11: begin opa = sx36(item_q.ddy[0]); opb = iy; sh = SH_F1; end
			5'd12: begin opa = sx36(item_q.ddy[1]); opb = iy; sh = SH_F1; end
			5'd13: begin opa = mua - mub; opb = iy; sh = SH_F1; end
			5'd14: begin opa = lama - lamb; opb = iy; sh = SH_F1; end
			5'd15: begin
				opa = ((mua <<< 1) + lama) - ((mub <<< 1) + lamb);
				opb = iy;
				sh  = SH_F1;
			end
			5'd16: begin opa = (mu <<< 1) + lam; opb = res_q[3]; end
			5'd17: begin opa = lam + mu; opb = res_q[8]; end
			5'd18: begin opa = mu; opb = res_q[5]; end
			5'd19: begin opa = res_q[13]; opb = res_q[11]; end
			5'd20: begin opa = res_q[13]; opb = res_q[10]; end
			5'd21: begin opa = mu + lam; opb = res_q[7]; end
			5'd22: begin opa = mu; opb = res_q[4]; end
			5'd23: begin opa = (mu <<< 1) + lam; opb = res_q[6]; end
			5'd24: begin opa = res_q[14]; opb = res_q[9]; end
			5'd25: begin opa = res_q[15]; opb = res_q[12]; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign req.start = (bst_q == B_ISSUE);
	assign req.a     = opa;
	assign req.b     = opb;
	assign req.sh    = sh;

	esa_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign q_pop     = (bst_q == B_IDLE) && q_valid;
	assign out_valid = out_valid_q;

	// Negate and clip each force to 32 bits.
	always_comb begin
		nfx = 64'sd0 - fx_q;
		nfy = 64'sd0 - fy_q;
		sx  = 1'b0;
		sy  = 1'b0;
		cx  = nfx;
		cy  = nfy;
		if (nfx > 64'sd2147483647) begin
			cx = 64'sd2147483647; sx = 1'b1;
		end else if (nfx < -64'sd2147483648) begin
			cx = -64'sd2147483648; sx = 1'b1;
		end
		if (nfy > 64'sd2147483647) begin
			cy = 64'sd2147483647; sy = 1'b1;
		end else if (nfy < -64'sd2147483648) begin
			cy = -64'sd2147483648; sy = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (bst_q)
				B_IDLE: begin
					if (q_valid) begin
						bst_q  <= B_ISSUE;
						step_q <= '0;
					end
				end
				B_ISSUE: bst_q <= B_WAIT;
				B_WAIT: begin
					if (rsp.done) begin
						if (step_q == LAST_STEP) begin
							bst_q <= B_FIN;
						end else begin
							step_q <= step_q + 5'd1;
							bst_q  <= B_ISSUE;
						end
					end
				end
				B_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						bst_q       <= B_IDLE;
					end
				end
				default: bst_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			fx_q   <= '0;
			fy_q   <= '0;
			clip_q <= 1'b0;
		end
		if (bst_q == B_WAIT && rsp.done) begin
			clip_q <= clip_q | rsp.clip;
			if (!step_q[4]) res_q[step_q[3:0]] <= $signed(rsp.res);
			else if (step_q <= LAST_FX) fx_q <= fx_q + $signed(rsp.res);
			else fy_q <= fy_q + $signed(rsp.res);
		end
		if (bst_q == B_FIN && (!out_valid_q || out_ready)) begin
			force_x    <= cx[31:0];
			force_y    <= cy[31:0];
			out_column <= item_q.col;
			out_row    <= item_q.row - ROW_W'(2);
			saturated  <= clip_q | sx | sy;
		end
	end

endmodule

[hw/rtl/elasticity_stencil_apply_unit.sv]
// ----------------------------------------------------------------------------
// elasticity_stencil_apply_unit
// Streaming 2D linear-elasticity stencil: displacement samples in, forces out.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ------------------------------------------
//   input     in_valid / in_ready     disp_x, disp_y, frame_start
//   output    out_valid / out_ready   force_x, force_y, out_column, out_row,
//                                     saturated
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The front cannot take a new sample request until it is through with the
// last: it reads the two line buffers at the column on accept, then shifts
// the window and writes back. A sample that completes an interior point
// then passes a push state, held while the queue is full, to hand it over.
// Each interior point then passes through the back: it is popped, its 26
// products go one after another through a single multiplier (issue, the
// multiplier's own steps, taking the result), and the output register is
// loaded.
// Reset clears the counters, the window and the control state; the line
// buffers are not cleared. A two-entry queue and the output register let the
// front keep taking samples while the back works or the output stalls.
// ----------------------------------------------------------------------------
module elasticity_stencil_apply_unit import esa_pkg::*; #(
	parameter int ROW_MAX   = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] disp_x,
	input  logic signed [31:0] disp_y,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic [COL_W-1:0]   out_column,
	output logic [ROW_W-1:0]   out_row,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [DATA_W-1:0]  cfg_data
);

	esa_cfg_t  cfg_q;
	esa_item_t push_item, head;
	logic      push, full, pop, q_valid;

	// Configuration writes always taken; user keeps block idle, unenforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mu_upper        <= RST_MU_UPPER;
			cfg_q.lambda_upper    <= RST_LAMBDA_UPPER;
			cfg_q.mu_lower        <= RST_MU_LOWER;
			cfg_q.lambda_lower    <= RST_LAMBDA_LOWER;
			cfg_q.inv_cell_x      <= RST_INV_CELL;
			cfg_q.inv_cell_y      <= RST_INV_CELL;
			cfg_q.row_width       <= RST_ROW_WIDTH;
			cfg_q.upper_start_row <= RST_UPPER_START;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MU_UPPER:     cfg_q.mu_upper        <= cfg_data[CONST_W-1:0];
				REG_LAMBDA_UPPER: cfg_q.lambda_upper    <= cfg_data[CONST_W-1:0];
				REG_MU_LOWER:     cfg_q.mu_lower        <= cfg_data[CONST_W-1:0];
				REG_LAMBDA_LOWER: cfg_q.lambda_lower    <= cfg_data[CONST_W-1:0];
				REG_INV_CELL_X:   cfg_q.inv_cell_x      <= cfg_data[CONST_W-1:0];
				REG_INV_CELL_Y:   cfg_q.inv_cell_y      <= cfg_data[CONST_W-1:0];
				REG_ROW_WIDTH:    cfg_q.row_width       <= cfg_data[RW_W-1:0];
				REG_UPPER_START:  cfg_q.upper_start_row <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: counters, line buffers and window; hands differences to the queue.
	esa_front #(.ROW_MAX(ROW_MAX)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_width   (cfg_q.row_width),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.disp_x      (disp_x),
		.disp_y      (disp_y),
		.frame_start (frame_start),
		.q_full      (full),
		.q_push      (push),
		.q_item      (push_item)
	);

	esa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (head)
	);

	// Back: material selection, scaled products, force sums and output register.
	esa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_item     (head),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.force_x    (force_x),
		.force_y    (force_y),
		.out_column (out_column),
		.out_row    (out_row),
		.saturated  (saturated)
	);

endmodule

[hw/rtl/esa_checker.sv]
// ----------------------------------------------------------------------------
// esa_checker
// Port-level checks on the stencil unit, bound to the top level.
// ----------------------------------------------------------------------------
module esa_checker import esa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [31:0] disp_x,
	input logic signed [31:0] disp_y,
	input logic               frame_start,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] force_x,
	input logic signed [31:0] force_y,
	input logic [COL_W-1:0]   out_column,
	input logic [ROW_W-1:0]   out_row,
	input logic               saturated,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [IDX_W-1:0]   cfg_index,
	input logic [DATA_W-1:0]  cfg_data
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(force_y)
			&& $stable(out_column) && $stable(out_row) && $stable(saturated))
		else $error("result changed while stalled");

	// After accepting a sample, the front is not ready until the line buffer write-back.
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken in back-to-back cycles");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind elasticity_stencil_apply_unit esa_checker u_esa_checker (.*);

[tb/elasticity_stencil_apply_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elasticity_stencil_apply_unit_tb
// Drives displacement tiles into the stencil unit under several material and
// geometry settings and checks every force request that comes out against a
// cycle-free predictor of the operator, with random idling on both channels.
// ----------------------------------------------------------------------------
module elasticity_stencil_apply_unit_tb;
	import esa_pkg::*;

	localparam int  FRAC       = 16;
	localparam int  LINE_MAX   = 1024;
	localparam int  RAND_ITEMS = 1150;
	localparam int  QUIET_MAX  = 20000;
	localparam int  SETTLE     = 400;
	localparam logic [127:0] INTER_LIM = (128'd1 << 60) - 128'd1;

	// One predicted force request.
	typedef struct {
		logic [31:0]      fx;
		logic [31:0]      fy;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             sat;
	} force_rec_t;

	// The scoreboard owns its own copy of the configuration and of the stencil
	// state, and turns every accepted sample into the force it should cause.
	class force_board;
		int unsigned mu_up, lam_up, mu_lo, lam_lo, inv_x, inv_y;
		int unsigned width_reg, upper_row, col_cnt, row_cnt, errors;
		logic [63:0] store_prev[LINE_MAX];
		logic [63:0] store_prev2[LINE_MAX];
		logic [63:0] win_r[9];
		bit clip_seen;
		force_rec_t forces_due[$];

		function new();
			mu_up = RST_MU_UPPER;
			lam_up = RST_LAMBDA_UPPER;
			mu_lo = RST_MU_LOWER;
			lam_lo = RST_LAMBDA_LOWER;
			inv_x = RST_INV_CELL;
			inv_y = RST_INV_CELL;
			width_reg = RST_ROW_WIDTH;
			upper_row = RST_UPPER_START;
			col_cnt = 0;
			row_cnt = 0;
			errors = 0;
			foreach (win_r[i]) win_r[i] = '0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_MU_UPPER:     mu_up = data[30:0];
				REG_LAMBDA_UPPER: lam_up = data[30:0];
				REG_MU_LOWER:     mu_lo = data[30:0];
				REG_LAMBDA_LOWER: lam_lo = data[30:0];
				REG_INV_CELL_X:   inv_x = data[30:0];
				REG_INV_CELL_Y:   inv_y = data[30:0];
				REG_ROW_WIDTH:    width_reg = data[10:0];
				REG_UPPER_START:  upper_row = data[19:0];
				default: ;
			endcase
		endfunction

		// Exact product, rounded half away from zero, clipped to 60 bits.
		function longint scaled_mul(longint a, longint b, int sh);
			logic [63:0] ma, mb;
			logic [127:0] p;
			bit neg;
			neg = (a < 0) != (b < 0);
			ma = (a < 0) ? 64'(-a) : 64'(a);
			mb = (b < 0) ? 64'(-b) : 64'(b);
			p = {64'd0, ma} * {64'd0, mb};
			p = (p + (128'd1 << (sh - 1))) >> sh;
			if (p > INTER_LIM) begin
				p = INTER_LIM;
				clip_seen = 1;
			end
			return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
		endfunction

		// rr 0 is the oldest row, cc 0 the leftmost column; k 1 picks y.
		function longint tap(int rr, int cc, int k);
			logic signed [31:0] h;
			h = k ? win_r[rr * 3 + cc][63:32] : win_r[rr * 3 + cc][31:0];
			return h;
		endfunction

		function void material(int unsigned row, output longint mu, output longint lam);
			if (row >= upper_row) begin
				mu = mu_up;
				lam = lam_up;
			end else begin
				mu = mu_lo;
				lam = lam_lo;
			end
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) begin
				clip_seen = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				clip_seen = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function void note_sample(logic [31:0] x, logic [31:0] y, bit fs);
			int unsigned w, c, r;
			longint ix, iy, sxx, syy, sxy, mu, lam, mua, lama, mub, lamb;
			longint cp, dmu, dlam, dstiff, fx, fy, d2x, d2y, dm;
			longint dxx[2], dyy[2], dxy[2], gx[2], gy[2];
			force_rec_t rec;
			w = width_reg;
			if (w < 3) w = 3;
			if (w > LINE_MAX) w = LINE_MAX;
			if (fs) begin
				col_cnt = 0;
				row_cnt = 0;
			end
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt = (row_cnt + 1) & 32'hFFFFF;
			end
			c = col_cnt;
			r = row_cnt;
			for (int rr = 0; rr < 3; rr++) begin
				win_r[rr * 3] = win_r[rr * 3 + 1];
				win_r[rr * 3 + 1] = win_r[rr * 3 + 2];
			end
			win_r[2] = store_prev2[c];
			win_r[5] = store_prev[c];
			win_r[8] = {y, x};
			store_prev2[c] = store_prev[c];
			store_prev[c] = {y, x};

			if (c >= 2 && r >= 2) begin
				clip_seen = 0;
				ix = inv_x;
				iy = inv_y;
				sxx = scaled_mul(ix, ix, FRAC);
				syy = scaled_mul(iy, iy, FRAC);
				sxy = scaled_mul(ix, iy, FRAC);
				for (int k = 0; k < 2; k++) begin
					d2x = tap(1, 2, k) - 2 * tap(1, 1, k) + tap(1, 0, k);
					d2y = tap(2, 1, k) - 2 * tap(1, 1, k) + tap(0, 1, k);
					dm = tap(2, 2, k) + tap(0, 0, k) - tap(0, 2, k) - tap(2, 0, k);
					dxx[k] = scaled_mul(d2x, sxx, FRAC);
					dyy[k] = scaled_mul(d2y, syy, FRAC);
					dxy[k] = scaled_mul(dm, sxy, FRAC + 2);
					gx[k] = scaled_mul(tap(1, 2, k) - tap(1, 0, k), ix, FRAC + 1);
					gy[k] = scaled_mul(tap(2, 1, k) - tap(0, 1, k), iy, FRAC + 1);
				end
				material(r - 1, mu, lam);
				material(r, mua, lama);
				material(r - 2, mub, lamb);
				cp = 2 * mu + lam;
				dmu = scaled_mul(mua - mub, iy, FRAC + 1);
				dlam = scaled_mul(lama - lamb, iy, FRAC + 1);
				dstiff = scaled_mul((2 * mua + lama) - (2 * mub + lamb), iy, FRAC + 1);
				fx = scaled_mul(cp, dxx[0], FRAC) + scaled_mul(lam + mu, dxy[1], FRAC)
					+ scaled_mul(mu, dyy[0], FRAC) + scaled_mul(dmu, gy[0], FRAC)
					+ scaled_mul(dmu, gx[1], FRAC);
				fy = scaled_mul(mu + lam, dxy[0], FRAC) + scaled_mul(mu, dxx[1], FRAC)
					+ scaled_mul(cp, dyy[1], FRAC) + scaled_mul(dlam, gx[0], FRAC)
					+ scaled_mul(dstiff, gy[1], FRAC);
				fx = clip32(-fx);
				fy = clip32(-fy);
				rec.fx = fx[31:0];
				rec.fy = fy[31:0];
				rec.col = COL_W'(c - 2);
				rec.row = ROW_W'(r - 2);
				rec.sat = clip_seen;
				forces_due.push_back(rec);
			end

			col_cnt = c + 1;
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt = (r + 1) & 32'hFFFFF;
			end
		endfunction

		function void check_force(logic [31:0] fx, logic [31:0] fy, logic [COL_W-1:0] col,
				logic [ROW_W-1:0] row, logic sat);
			force_rec_t e;
			if (forces_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected force at col %0d row %0d", col, row);
				return;
			end
			e = forces_due.pop_front();
			if (e.fx !== fx || e.fy !== fy || e.col !== col || e.row !== row || e.sat !== sat) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: force mismatch exp fx %h fy %h col %0d row %0d sat %b, got fx %h fy %h col %0d row %0d sat %b",
						e.fx, e.fy, e.col, e.row, e.sat, fx, fy, col, row, sat);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] disp_x = '0;
	logic signed [31:0] disp_y = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] force_x, force_y;
	logic [COL_W-1:0] out_column;
	logic [ROW_W-1:0] out_row;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	force_board board;
	int unsigned idle_pct_in = 0;
	int unsigned idle_pct_out = 0;
	int unsigned samples_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned settings[8];

	always #10 clk = ~clk;

	elasticity_stencil_apply_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.disp_x(disp_x), .disp_y(disp_y), .frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.force_x(force_x), .force_y(force_y), .out_column(out_column),
		.out_row(out_row), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// The output side stalls at random; a force request is taken at an edge
	// where both valid and ready were high just before it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				board.check_force(force_x, force_y, out_column, out_row, saturated);
			out_ready <= ($urandom_range(99) >= idle_pct_out);
		end
	end

	// Any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Sends one sample request. Valid stays high on return so that the next
	// request can follow back to back; callers lower it when they stop.
	task automatic put_sample(input logic [31:0] x, input logic [31:0] y, input bit fs);
		while ($urandom_range(99) < idle_pct_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		disp_x <= x;
		disp_y <= y;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		board.note_sample(x, y, fs);
		samples_sent++;
	endtask

	// Waits for every predicted force, then gives the front time to finish
	// samples that cause no result before the registers may change.
	task automatic drain_forces();
		in_valid <= 1'b0;
		while (board.forces_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all eight registers from settings[]. Bits above each field are
	// filled with junk, which the block must ignore.
	task automatic write_settings();
		logic [DATA_W-1:0] d;
		logic [DATA_W-1:0] keep;
		for (int i = 0; i < 8; i++) begin
			keep = (i == REG_ROW_WIDTH) ? 32'h7FF :
				(i == REG_UPPER_START) ? 32'hFFFFF : 32'h7FFFFFFF;
			d = (settings[i] & keep) | ($urandom & ~keep);
			cfg_valid <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= d;
			do @(posedge clk); while (!cfg_ready);
			board.set_reg(IDX_W'(i), d);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic int unsigned pick_const();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) return 0;
		if (r < 20) return 32'h7FFFFFFF;
		return $urandom_range(0, 1 << 20);
	endfunction

	function automatic int unsigned pick_inv();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return 1;
		if (r < 16) return 32'h7FFFFFFF;
		return $urandom_range(16384, 262144);
	endfunction

	// Mostly small displacements, so that the forces stay in range, with full
	// random words and the two's complement extremes mixed in.
	function automatic logic [31:0] pick_disp();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(0, 1 << 19) - (1 << 18);
		if (r < 90) return $urandom;
		case ($urandom_range(3))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	function automatic int unsigned eff_width(int unsigned w);
		if (w < 3) return 3;
		if (w > LINE_MAX) return LINE_MAX;
		return w;
	endfunction

	// One tile: the first sample opens it. A stray frame start now and then
	// restarts the tile in the middle.
	task automatic send_tile(input int unsigned count, input bit noisy);
		for (int unsigned i = 0; i < count; i++)
			put_sample(pick_disp(), pick_disp(), (i == 0) || (noisy && $urandom_range(99) < 2));
	endtask

	function automatic void random_settings();
		int unsigned r;
		settings[REG_MU_UPPER] = pick_const();
		settings[REG_LAMBDA_UPPER] = pick_const();
		settings[REG_MU_LOWER] = pick_const();
		settings[REG_LAMBDA_LOWER] = pick_const();
		settings[REG_INV_CELL_X] = pick_inv();
		settings[REG_INV_CELL_Y] = pick_inv();
		r = $urandom_range(99);
		settings[REG_ROW_WIDTH] = (r < 75) ? $urandom_range(3, 8) :
			(r < 90) ? $urandom_range(0, 2) : $urandom_range(9, 40);
		r = $urandom_range(99);
		settings[REG_UPPER_START] = (r < 10) ? 32'hFFFFF : $urandom_range(0, 6);
	endfunction

	initial begin
		int unsigned phase, w, rows;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: narrowest tiles, saturating rows of both extremes,
		// then a calm tile whose interface sits inside it.
		settings = '{RST_MU_UPPER, RST_LAMBDA_UPPER, RST_MU_LOWER, RST_LAMBDA_LOWER,
			RST_INV_CELL, RST_INV_CELL, 3, 0};
		write_settings();
		for (int i = 0; i < 9; i++)
			put_sample((i / 3 == 1) ? 32'h80000000 : 32'h7FFFFFFF,
				(i / 3 == 1) ? 32'h7FFFFFFF : 32'h80000000, i == 0);
		drain_forces();
		settings[REG_UPPER_START] = 3;
		write_settings();
		for (int i = 0; i < 12; i++)
			put_sample((i % 2) ? 32'h00010000 : 32'h0, (i % 3) ? 32'hFFFF0000 : 32'h0, i == 0);
		drain_forces();

		phase = 0;
		while (samples_sent < 21 + RAND_ITEMS) begin
			case (phase % 4)
				0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
				1: begin idle_pct_in = 62; idle_pct_out = 0;  end
				2: begin idle_pct_in = 0;  idle_pct_out = 62; end
				default: begin idle_pct_in = 14; idle_pct_out = 14; end
			endcase
			if (phase == 2) begin
				// Width shrunk in the middle of a row: the counter is past the
				// new width, so the stream moves to the next row first.
				random_settings();
				settings[REG_ROW_WIDTH] = 8;
				write_settings();
				send_tile(3 * 8 + 5, 0);
				drain_forces();
				settings[REG_ROW_WIDTH] = 4;
				write_settings();
				for (int i = 0; i < 12; i++)
					put_sample(pick_disp(), pick_disp(), 1'b0);
			end else if (phase == 5) begin
				// Widest rows, set through a width above the line length. The
				// first row wraps at the line length; a narrow width then moves
				// the stream on to the third row, which yields forces only if
				// the wrap happened.
				random_settings();
				settings[REG_ROW_WIDTH] = 2047;
				write_settings();
				send_tile(LINE_MAX + 6, 0);
				drain_forces();
				settings[REG_ROW_WIDTH] = 4;
				write_settings();
				for (int i = 0; i < 8; i++)
					put_sample(pick_disp(), pick_disp(), 1'b0);
			end else begin
				random_settings();
				if (phase == 7) begin
					// Zero cell reciprocal and the largest constants.
					settings[REG_INV_CELL_X] = 0;
					settings[REG_MU_UPPER] = 32'h7FFFFFFF;
					settings[REG_LAMBDA_LOWER] = 32'h7FFFFFFF;
				end
				write_settings();
				w = eff_width(settings[REG_ROW_WIDTH]);
				repeat ($urandom_range(1, 3)) begin
					rows = $urandom_range(3, 6);
					send_tile(rows * w + $urandom_range(0, w - 1), 1);
				end
			end
			drain_forces();
			phase++;
		end

		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
